>>> rtl/sync_length_crc16_frame_receiver_defines.svh
// Assertion macros for the sync/length/CRC16 frame receiver.
// Included by the top level; no other dependencies.
`ifndef SYNC_LENGTH_CRC16_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LENGTH_CRC16_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every clock edge out of reset.
`define SLCFR_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("frame receiver check failed");
// Next-cycle implication, checked at every clock edge out of reset.
`define SLCFR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("frame receiver check failed");
`else
`define SLCFR_ASSERT_NOW(label, clk, rst_n, pre, post)
`define SLCFR_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/slcfr_pkg.sv
// Package for the sync/length/CRC16 frame receiver: frame constants,
// event codes and the byte-wide CRC-16 update. No dependencies.
package slcfr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned POS_W  = 9;
	localparam int unsigned KIND_W = 3;

	localparam logic [BYTE_W-1:0] SOF_BYTE  = 8'h11;
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
	localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8005;

	// Byte positions within the frame header.
	localparam logic [POS_W-1:0] POS_SOF     = 9'd0;
	localparam logic [POS_W-1:0] POS_SYNC    = 9'd1;
	localparam logic [POS_W-1:0] POS_CODE    = 9'd2;
	localparam logic [POS_W-1:0] POS_CMD_LO  = 9'd3;
	localparam logic [POS_W-1:0] POS_CMD_HI  = 9'd4;
	localparam logic [POS_W-1:0] POS_LEN     = 9'd5;
	localparam logic [POS_W-1:0] HDR_LEN     = 9'd6;
	// Header plus the two CRC bytes, minus one: last byte offset past payload.
	localparam logic [POS_W-1:0] LAST_OFFSET = 9'd7;
	// Highest position the counter can reach (full payload, last CRC byte).
	localparam logic [POS_W-1:0] POS_MAX     = 9'd262;

	typedef enum logic [KIND_W-1:0] {
		EV_DROP = 3'd0,
		EV_HELD = 3'd1,
		EV_DATA = 3'd2,
		EV_GOOD = 3'd3,
		EV_BAD  = 3'd4
	} event_kind_t;

	// Non-reflected CRC-16, one byte folded in MSB first.
	function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/sync_length_crc16_frame_receiver.sv
// Path: each byte passes the input register, then the result register, where its result is valid.
// Throughput: one byte per cycle while unstalled; CRC update and header decode sit in one stage.
// Backpressure on the result channel stalls the input register, then the input channel.
// Reset (arst_n low, asynchronous) clears both valid flags and the frame state:
// no frame in progress, CRC at 0xFFFF, held code, command and length at zero.
`include "sync_length_crc16_frame_receiver_defines.svh"

// Top level of the frame receiver. Depends on slcfr_pkg and the defines header.
module sync_length_crc16_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_ready,
	input  logic [slcfr_pkg::BYTE_W-1:0]      rx_byte,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [slcfr_pkg::KIND_W-1:0]      event_kind,
	output logic [slcfr_pkg::BYTE_W-1:0]      payload_byte,
	output logic [slcfr_pkg::BYTE_W-1:0]      payload_index,
	output logic [slcfr_pkg::BYTE_W-1:0]      frame_code,
	output logic [2*slcfr_pkg::BYTE_W-1:0]    frame_command,
	output logic [slcfr_pkg::BYTE_W-1:0]      frame_length
);
	import slcfr_pkg::*;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Frame state.
	logic [POS_W-1:0]    pos_q;
	logic [CRC_W-1:0]    crc_q;
	logic [BYTE_W-1:0]   code_q;
	logic [2*BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0]   len_q;

	// Result register.
	logic                out_valid_q;
	event_kind_t         kind_q;
	logic [BYTE_W-1:0]   pbyte_q;
	logic [BYTE_W-1:0]   pidx_q;
	logic [BYTE_W-1:0]   code_out_q;
	logic [2*BYTE_W-1:0] cmd_out_q;
	logic [BYTE_W-1:0]   len_out_q;

	// Handshake between the stages.
	logic advance_s1;
	assign advance_s1 = valid_s1 && (!out_valid_q || result_ready);
	assign byte_ready = !valid_s1 || advance_s1;

	// Decode of the byte in the input register against the frame state.
	logic                drop_n;
	logic [CRC_W-1:0]    crc_n;
	logic [BYTE_W-1:0]   code_n;
	logic [2*BYTE_W-1:0] cmd_n;
	logic [BYTE_W-1:0]   len_n;
	logic [POS_W-1:0]    data_end;
	logic [POS_W-1:0]    frame_last;
	logic [POS_W-1:0]    data_off;
	event_kind_t         kind_n;

	always_comb begin
		drop_n = ((pos_q == POS_SOF) && (byte_s1 != SOF_BYTE)) ||
			((pos_q == POS_SYNC) && (byte_s1 != SYNC_BYTE));
		crc_n  = crc16_feed(crc_q, byte_s1);
		code_n = (pos_q == POS_CODE) ? byte_s1 : code_q;
		cmd_n  = cmd_q;
		if (pos_q == POS_CMD_LO) begin
			cmd_n[BYTE_W-1:0] = byte_s1;
		end
		if (pos_q == POS_CMD_HI) begin
			cmd_n[2*BYTE_W-1:BYTE_W] = byte_s1;
		end
		len_n      = (pos_q == POS_LEN) ? byte_s1 : len_q;
		data_end   = {1'b0, len_n} + HDR_LEN;
		frame_last = {1'b0, len_n} + LAST_OFFSET;
		data_off   = pos_q - HDR_LEN;
		if (drop_n) begin
			kind_n = EV_DROP;
		end else if ((pos_q >= HDR_LEN) && (pos_q < data_end)) begin
			kind_n = EV_DATA;
		end else if ((pos_q >= HDR_LEN) && (pos_q >= frame_last)) begin
			kind_n = (crc_n == '0) ? EV_GOOD : EV_BAD;
		end else begin
			kind_n = EV_HELD;
		end
	end

	// A drop or a frame end sends the frame state back to idle.
	logic frame_done;
	assign frame_done = (kind_n == EV_DROP) || (kind_n == EV_GOOD) || (kind_n == EV_BAD);

	// Input register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// Input register: byte.
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state update, once per byte that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			code_q <= '0;
			cmd_q  <= '0;
			len_q  <= '0;
		end else if (advance_s1) begin
			if (frame_done) begin
				pos_q  <= '0;
				crc_q  <= CRC_INIT;
				code_q <= '0;
				cmd_q  <= '0;
				len_q  <= '0;
			end else begin
				pos_q  <= pos_q + 9'd1;
				crc_q  <= crc_n;
				code_q <= code_n;
				cmd_q  <= cmd_n;
				len_q  <= len_n;
			end
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload fields.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			kind_q <= kind_n;
			if (kind_n == EV_DATA) begin
				pbyte_q <= byte_s1;
				pidx_q  <= data_off[BYTE_W-1:0];
			end else begin
				pbyte_q <= '0;
				pidx_q  <= '0;
			end
			if (drop_n) begin
				code_out_q <= '0;
				cmd_out_q  <= '0;
				len_out_q  <= '0;
			end else begin
				code_out_q <= code_n;
				cmd_out_q  <= cmd_n;
				len_out_q  <= len_n;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign event_kind    = kind_q;
	assign payload_byte  = pbyte_q;
	assign payload_index = pidx_q;
	assign frame_code    = code_out_q;
	assign frame_command = cmd_out_q;
	assign frame_length  = len_out_q;

	// Summary terms for the checks below.
	logic state_idle;
	logic drop_fields_zero;
	assign state_idle = (pos_q == '0) && (crc_q == CRC_INIT) && (len_q == '0);
	assign drop_fields_zero = (code_out_q == '0) && (cmd_out_q == '0) &&
		(len_out_q == '0) && (pbyte_q == '0);

	// A frame end or a drop leaves the state at its reset values.
	`SLCFR_ASSERT_NEXT(a_clear_after_end, clk, arst_n, advance_s1 && frame_done, state_idle)
	// The position counter never runs past the longest frame.
	`SLCFR_ASSERT_NOW(a_pos_bound, clk, arst_n, 1'b1, pos_q <= POS_MAX)
	// A payload byte always lies inside the announced length.
	`SLCFR_ASSERT_NOW(a_index_in_len, clk, arst_n, out_valid_q && kind_q == EV_DATA, pidx_q < len_out_q)
	// A dropped byte reports no frame fields.
	`SLCFR_ASSERT_NOW(a_drop_clean, clk, arst_n, out_valid_q && kind_q == EV_DROP, drop_fields_zero)

endmodule
